>>> hw/rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing else.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic deq;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and moves it to the right on
// insert or to the left on dequeue. Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_new,
    input  logic               i_left_ge,
    input  spq_pkg::t_entry    i_left_q,
    input  spq_pkg::t_entry    i_right_q,
    output logic               o_ge,
    output spq_pkg::t_entry    o_q
);

    spq_pkg::t_entry r_q;
    spq_pkg::t_entry n_q;

    // The entry stays in place when it is ahead of the new one.
    assign o_ge = i_occ && (r_q.prio <= i_new.prio);
    assign o_q  = r_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.ins) begin
            if (!o_ge) begin
                n_q = i_left_ge ? i_new : i_left_q;
            end
        end else if (i_ctl.deq) begin
            n_q = i_right_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

>>> hw/rtl/stable_priority_queue.sv
// Top level of the stable priority queue: a chain of spq_cell slots, the
// entry count, the dump sequencer and the output register.
// Depends on spq_pkg and spq_cell.
//
// Usage: one request word enters on the input channel (i_in_valid,
// o_in_stall) and each result word leaves on the output channel
// (o_out_valid, i_out_stall). A word moves when valid is high and stall is
// low. Entries are kept sorted by ascending signed priority in a chain of
// CAPACITY cells; equal priorities keep their arrival order.
// Insert and dequeue: every cell compares its priority with the new one in
// parallel and either holds, takes the new entry or takes its neighbor's
// entry. Their result appears in the output register on the cycle after the
// request is accepted, and a new request is taken every cycle as long as the
// receiver does not stall.
// A dump of n entries emits n words from head to tail, one per cycle while
// the receiver does not stall, with o_last on the tail; the input is
// stalled until the tail word is loaded.
// A dump or dequeue of an empty queue gives one empty word.
// Request code 3 is taken and ignored.
// Reset empties the queue and clears the output valid; cell contents are
// not cleared. When the receiver stalls, the pending word holds and the
// input channel stalls until the word is taken.
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [spq_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_item_priority,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [spq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic                                o_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // Queue state.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    spq_pkg::t_state   r_state;
    spq_pkg::t_state   n_state;
    logic [IDX_W-1:0]  r_dump_idx;
    logic [IDX_W-1:0]  n_dump_idx;

    // Output register.
    logic                          r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]  r_status;
    spq_pkg::t_entry               r_out_entry;
    logic                          r_last;

    // Result to load into the output register this cycle.
    logic                          w_load;
    logic [spq_pkg::STATUS_W-1:0]  w_status;
    spq_pkg::t_entry               w_entry;
    logic                          w_last;

    logic                w_in_accept;
    logic                w_out_free;
    logic                w_full;
    logic                w_empty;
    spq_pkg::t_cell_ctl  w_ctl;
    spq_pkg::t_entry     w_new;

    // Chain wiring.
    spq_pkg::t_entry  w_cell_q  [CAPACITY];
    logic             w_cell_ge [CAPACITY];
    logic             w_occ     [CAPACITY];

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != spq_pkg::S_IDLE) || !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);

    assign w_new.value = i_item_value;
    assign w_new.prio  = i_item_priority;

    // Each cell sees its left neighbor's compare result and entry; the head
    // cell always counts as the insert point when its own entry is behind.
    // The tail cell takes its own entry on dequeue, which is never read.
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_occ[g] = (CNT_W'(g) < r_count);

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_occ     (w_occ[g]),
                .i_new     (w_new),
                .i_left_ge ((g == 0) ? 1'b1 : w_cell_ge[(g == 0) ? 0 : g - 1]),
                .i_left_q  (w_cell_q[(g == 0) ? 0 : g - 1]),
                .i_right_q (w_cell_q[(g == CAPACITY - 1) ? g : g + 1]),
                .o_ge      (w_cell_ge[g]),
                .o_q       (w_cell_q[g])
            );
        end
    endgenerate

    // Request decode and dump sequencer.
    always_comb begin
        n_state    = r_state;
        n_dump_idx = r_dump_idx;
        n_count    = r_count;
        w_ctl      = '0;
        w_load     = 1'b0;
        w_status   = spq_pkg::STATUS_OK;
        w_entry    = '0;
        w_last     = 1'b1;

        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    case (i_req_type)
                        spq_pkg::REQ_INSERT: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_status = spq_pkg::STATUS_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        spq_pkg::REQ_DEQUEUE: begin
                            w_load = 1'b1;
                            if (w_empty) begin
                                w_status = spq_pkg::STATUS_EMPTY;
                            end else begin
                                w_entry   = w_cell_q[0];
                                w_ctl.deq = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        spq_pkg::REQ_DUMP: begin
                            if (w_empty) begin
                                w_load   = 1'b1;
                                w_status = spq_pkg::STATUS_EMPTY;
                            end else begin
                                n_state    = spq_pkg::S_DUMP;
                                n_dump_idx = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            spq_pkg::S_DUMP: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_entry = w_cell_q[r_dump_idx];
                    w_last  = ((CNT_W'(r_dump_idx) + CNT_W'(1)) == r_count);
                    if (w_last) begin
                        n_state = spq_pkg::S_IDLE;
                    end else begin
                        n_dump_idx = r_dump_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= w_status;
            r_out_entry <= w_entry;
            r_last      <= w_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_out_entry.value;
    assign o_out_priority = r_out_entry.prio;
    assign o_last         = r_last;

endmodule

>>> test/stable_priority_queue_tb.sv
// Self-checking testbench for stable_priority_queue: named test tasks drive request words,
// a sorted-list predictor computes the result words, and a checker compares them.
// Depends on spq_pkg and the stable_priority_queue RTL.
module stable_priority_queue_tb;

    localparam int CAPACITY     = spq_pkg::CAPACITY_DEF;
    localparam int MAX_SHOWN    = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [spq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // One result word as the block should present it.
    typedef struct {
        logic [spq_pkg::STATUS_W-1:0]       status;
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic signed [spq_pkg::PRIO_W-1:0]  prio;
        logic                               last;
    } t_result_word;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [spq_pkg::REQ_W-1:0]           i_req_type;
    logic signed [spq_pkg::VALUE_W-1:0]  i_item_value;
    logic signed [spq_pkg::PRIO_W-1:0]   i_item_priority;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [spq_pkg::STATUS_W-1:0]        o_status;
    logic signed [spq_pkg::VALUE_W-1:0]  o_out_value;
    logic signed [spq_pkg::PRIO_W-1:0]   o_out_priority;
    logic                                o_last;

    stable_priority_queue #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_item_priority(i_item_priority),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_last         (o_last)
    );

    // Shadow copy of the sorted store and the words still owed by the block.
    spq_pkg::t_entry  sorted_slots [CAPACITY];
    int               stored_count;
    t_result_word     due_words [$];

    int fail_count;
    int send_gap_max;
    int recv_gap_max;
    int recv_gap_left;
    bit hold_request;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sorted-list queue: applies one accepted request to the shadow store
    // and queues every result word it causes.
    function automatic void sorted_queue_step(
        input logic [spq_pkg::REQ_W-1:0] req,
        input logic signed [spq_pkg::VALUE_W-1:0] value,
        input logic signed [spq_pkg::PRIO_W-1:0] prio);
        t_result_word w;
        int pos;
        w.status = spq_pkg::STATUS_OK;
        w.value  = '0;
        w.prio   = '0;
        w.last   = 1'b1;
        case (req)
            spq_pkg::REQ_INSERT: begin
                if (stored_count >= CAPACITY) begin
                    w.status = spq_pkg::STATUS_FULL;
                end else begin
                    // A new entry goes behind every entry of equal or
                    // smaller priority, which keeps ties in arrival order.
                    pos = 0;
                    while (pos < stored_count && $signed(sorted_slots[pos].prio) <= prio)
                        pos++;
                    for (int j = stored_count; j > pos; j--)
                        sorted_slots[j] = sorted_slots[j-1];
                    sorted_slots[pos].value = value;
                    sorted_slots[pos].prio  = prio;
                    stored_count++;
                end
                due_words.push_back(w);
            end
            spq_pkg::REQ_DEQUEUE: begin
                if (stored_count == 0) begin
                    w.status = spq_pkg::STATUS_EMPTY;
                end else begin
                    w.value = sorted_slots[0].value;
                    w.prio  = sorted_slots[0].prio;
                    for (int j = 1; j < stored_count; j++)
                        sorted_slots[j-1] = sorted_slots[j];
                    stored_count--;
                end
                due_words.push_back(w);
            end
            spq_pkg::REQ_DUMP: begin
                if (stored_count == 0) begin
                    w.status = spq_pkg::STATUS_EMPTY;
                    due_words.push_back(w);
                end else begin
                    for (int j = 0; j < stored_count; j++) begin
                        w.value = sorted_slots[j].value;
                        w.prio  = sorted_slots[j].prio;
                        w.last  = (j == stored_count - 1);
                        due_words.push_back(w);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one request word after a random gap and waits until the block
    // takes it. Valid stays high between back-to-back words.
    task automatic send_word(input logic [spq_pkg::REQ_W-1:0] req,
                             input logic signed [spq_pkg::VALUE_W-1:0] value,
                             input logic signed [spq_pkg::PRIO_W-1:0] prio);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_item_value    <= value;
        i_item_priority <= prio;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sorted_queue_step(req, value, prio);
    endtask

    // Draws one request. Narrow priorities give many ties.
    task automatic send_random(input int ins_w, input int deq_w, input int dump_w,
                               input int noise_w);
        int roll;
        logic [spq_pkg::REQ_W-1:0] req;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        roll = $urandom_range(0, ins_w + deq_w + dump_w + noise_w - 1);
        if (roll < ins_w)                       req = spq_pkg::REQ_INSERT;
        else if (roll < ins_w + deq_w)          req = spq_pkg::REQ_DEQUEUE;
        else if (roll < ins_w + deq_w + dump_w) req = spq_pkg::REQ_DUMP;
        else                                    req = REQ_UNUSED;
        if ($urandom_range(0, 1))
            prio = $signed(spq_pkg::PRIO_W'($urandom_range(0, 3))) - 16'sd1;
        else
            prio = spq_pkg::PRIO_W'($urandom);
        send_word(req, $urandom, prio);
    endtask

    // Stops offering words and waits until every owed word has come.
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_gap_max = 3;
        recv_gap_max = 3;
        send_word(spq_pkg::REQ_DEQUEUE, 32'sd0, 16'sd0);
        send_word(spq_pkg::REQ_DUMP, 32'sd0, 16'sd0);
        send_word(REQ_UNUSED, -32'sd1, -16'sd1);
        send_word(spq_pkg::REQ_DEQUEUE, -32'sd1, -16'sd1);
        wait_drain();
    endtask

    // Extreme values and priorities, and ties at both ends of the range.
    task automatic test_extremes();
        send_gap_max = 0;
        recv_gap_max = 0;
        send_word(spq_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
        send_word(spq_pkg::REQ_INSERT, 32'sh8000_0000, 16'sh8000);
        send_word(spq_pkg::REQ_INSERT, 32'sd0, 16'sd0);
        send_word(spq_pkg::REQ_INSERT, -32'sd1, -16'sd1);
        send_word(spq_pkg::REQ_INSERT, 32'sd5, 16'sd0);
        send_word(spq_pkg::REQ_INSERT, 32'sd6, 16'sh7FFF);
        send_word(spq_pkg::REQ_INSERT, 32'sd7, 16'sh8000);
        send_word(REQ_UNUSED, 32'sh7FFF_FFFF, 16'sh7FFF);
        send_word(spq_pkg::REQ_DUMP, -32'sd1, -16'sd1);
        send_word(spq_pkg::REQ_DEQUEUE, 32'sd0, 16'sd0);
        send_word(spq_pkg::REQ_DEQUEUE, 32'sd0, 16'sd0);
        send_word(spq_pkg::REQ_DUMP, 32'sd0, 16'sd0);
        wait_drain();
    endtask

    // Fills the queue, overruns it, dumps it whole and empties it again.
    task automatic test_overflow();
        send_gap_max = 19;
        recv_gap_max = 19;
        while (stored_count > 0)
            send_word(spq_pkg::REQ_DEQUEUE, $urandom, spq_pkg::PRIO_W'($urandom));
        while (stored_count < CAPACITY)
            send_random(1, 0, 0, 0);
        send_random(1, 0, 0, 0);
        send_word(spq_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 16'sh8000);
        send_word(spq_pkg::REQ_DUMP, $urandom, spq_pkg::PRIO_W'($urandom));
        while (stored_count > 0)
            send_word(spq_pkg::REQ_DEQUEUE, $urandom, spq_pkg::PRIO_W'($urandom));
        send_word(spq_pkg::REQ_DEQUEUE, $urandom, spq_pkg::PRIO_W'($urandom));
        wait_drain();
    endtask

    // Random mix in chunks with different idling on each side.
    task automatic test_random_mix();
        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0: begin send_gap_max = 19; recv_gap_max = 19; end
                1: begin send_gap_max = 0;  recv_gap_max = 0;  end
                2: begin send_gap_max = 0;  recv_gap_max = 19; end
                default: begin send_gap_max = 19; recv_gap_max = 0; end
            endcase
            for (int k = 0; k < 25; k++) begin
                if (chunk == 3)
                    send_random(25, 45, 20, 10);
                else
                    send_random(50, 25, 15, 10);
            end
        end
        wait_drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the output register fills and the input stalls.
    task automatic test_backpressure();
        send_gap_max = 0;
        recv_gap_max = 2;
        hold_request = 1'b1;
        for (int k = 0; k < 30; k++)
            send_random(60, 20, 15, 5);
        wait_drain();
    endtask

    // Receiver: stalls for the drawn gap after each taken word, and for a
    // long stretch when a test asks for one.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (recv_gap_left > 0) begin
                i_out_stall <= 1'b1;
                recv_gap_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Checker: each taken result word against the oldest owed word.
    always @(posedge i_clk) begin
        t_result_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            recv_gap_left = $urandom_range(0, recv_gap_max);
            if (due_words.size() == 0) begin
                if (fail_count < MAX_SHOWN)
                    $display("unexpected word: status %0d value %0d prio %0d last %0b",
                             o_status, o_out_value, o_out_priority, o_last);
                fail_count++;
            end else begin
                w = due_words.pop_front();
                if (o_status !== w.status || o_out_value !== w.value ||
                    o_out_priority !== w.prio || o_last !== w.last) begin
                    if (fail_count < MAX_SHOWN)
                        $display({"mismatch: exp status %0d value %0d prio %0d last %0b,",
                                  " got status %0d value %0d prio %0d last %0b"},
                                 w.status, w.value, w.prio, w.last,
                                 o_status, o_out_value, o_out_priority, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("** stable_priority_queue: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        fail_count      = 0;
        stored_count    = 0;
        send_gap_max    = 0;
        recv_gap_max    = 0;
        recv_gap_left   = 0;
        hold_request    = 1'b0;
        quiet_cycles    = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_req_type      = spq_pkg::REQ_INSERT;
        i_item_value    = '0;
        i_item_priority = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_extremes();
        test_overflow();
        test_random_mix();
        test_backpressure();
        test_overflow();

        fail_count += due_words.size();
        if (fail_count == 0) begin
            $display("** stable_priority_queue: PASSED **");
        end else begin
            $display("** stable_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule
